/* sv/pbli_pkg.sv */
// ----------------------------------------------------------------------------
// pbli_pkg: shared types and constants of the blank line inserter
// Holds the configuration and per-tick result bundles, the register indexes
// used by the register block and the fixed line timing constants of the sync core.
// ----------------------------------------------------------------------------
package pbli_pkg;

    // Generated line timing, in video ticks.
    localparam logic [9:0] LINE_TICKS  = 10'd912;
    localparam logic [9:0] PULSE_TICKS = 10'd64;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_FIRST_DELAY  = 3'd0;
    localparam logic [2:0] REG_SECOND_DELAY = 3'd1;
    localparam logic [2:0] REG_FIRST_STOP   = 3'd2;
    localparam logic [2:0] REG_SECOND_STOP  = 3'd3;
    localparam logic [2:0] REG_SYNC_INHIBIT = 3'd4;

    typedef struct packed {
        logic [7:0] first_delay_lines;
        logic [7:0] second_delay_lines;
        logic [8:0] first_stop_line;
        logic [8:0] second_stop_line;
        logic       sync_inhibit;
    } t_cfg;

    typedef struct packed {
        logic hsync_out;
        logic fsync_out;
        logic chip_pause;
        logic blank_line_strobe;
    } t_result;

endpackage

/* sv/pbli_cfg.sv */
// ----------------------------------------------------------------------------
// pbli_cfg: configuration registers
// APB-style register file holding the delay counts, stop lines and the sync
// inhibit bit. Registers sit at byte address 4*index.
// ----------------------------------------------------------------------------
module pbli_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output pbli_pkg::t_cfg    o_cfg
);

    pbli_pkg::t_cfg r_cfg;
    logic [2:0]     w_index;
    logic           w_write;

    assign w_index = paddr[4:2];
    assign w_write = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_write) begin
            case (w_index)
                pbli_pkg::REG_FIRST_DELAY:  r_cfg.first_delay_lines  <= pwdata[7:0];
                pbli_pkg::REG_SECOND_DELAY: r_cfg.second_delay_lines <= pwdata[7:0];
                pbli_pkg::REG_FIRST_STOP:   r_cfg.first_stop_line    <= pwdata[8:0];
                pbli_pkg::REG_SECOND_STOP:  r_cfg.second_stop_line   <= pwdata[8:0];
                pbli_pkg::REG_SYNC_INHIBIT: r_cfg.sync_inhibit       <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_index)
            pbli_pkg::REG_FIRST_DELAY:  prdata = {24'd0, r_cfg.first_delay_lines};
            pbli_pkg::REG_SECOND_DELAY: prdata = {24'd0, r_cfg.second_delay_lines};
            pbli_pkg::REG_FIRST_STOP:   prdata = {23'd0, r_cfg.first_stop_line};
            pbli_pkg::REG_SECOND_STOP:  prdata = {23'd0, r_cfg.second_stop_line};
            pbli_pkg::REG_SYNC_INHIBIT: prdata = {31'd0, r_cfg.sync_inhibit};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

/* sv/pbli_core.sv */
// ----------------------------------------------------------------------------
// pbli_core: sync tracking and line generation
// Holds the edge history, scanline counter and insertion timing, and computes
// one tick's result from the registered sync levels.
// ----------------------------------------------------------------------------
module pbli_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_hs,
    input  logic                i_fs,
    input  pbli_pkg::t_cfg      i_cfg,
    output pbli_pkg::t_result   o_result
);

    logic       r_prev_hsync, n_prev_hsync;
    logic       r_prev_fsync, n_prev_fsync;
    logic [8:0] r_scanline,   n_scanline;
    logic [7:0] r_remaining,  n_remaining;
    logic [9:0] r_timer,      n_timer;
    logic       r_inserting,  n_inserting;
    logic       r_level,      n_level;
    logic       w_strobe;

    always_comb begin
        n_scanline  = r_scanline;
        n_remaining = r_remaining;
        n_timer     = r_timer;
        n_inserting = r_inserting;
        n_level     = r_level;
        w_strobe    = 1'b0;

        // Locally generated line timing comes first.
        if (r_inserting) begin
            n_timer = r_timer + 10'd1;
            if (n_timer == pbli_pkg::PULSE_TICKS) begin
                n_level = 1'b1;
            end
            if (n_timer == pbli_pkg::LINE_TICKS) begin
                w_strobe    = 1'b1;
                if (!i_cfg.sync_inhibit) begin
                    n_level = 1'b0;
                end
                n_remaining = r_remaining - 8'd1;
                if (n_remaining == 8'd0) begin
                    n_inserting = 1'b0;
                end else begin
                    n_timer = 10'd0;
                end
            end
        end

        // Frame sync rising edge restarts the scanline count.
        if (i_fs && !r_prev_fsync) begin
            n_scanline = 9'd0;
        end

        // A chip edge overrides any generated level in the same tick.
        if (i_hs != r_prev_hsync) begin
            n_level = i_hs;
            if (!i_hs && (i_cfg.first_delay_lines != 8'd0)) begin
                n_scanline = n_scanline + 9'd1;
                if (n_scanline == i_cfg.first_stop_line) begin
                    n_remaining = i_cfg.first_delay_lines;
                end else if (n_scanline == i_cfg.second_stop_line) begin
                    n_remaining = i_cfg.second_delay_lines;
                end
                if (n_remaining != 8'd0) begin
                    n_inserting = 1'b1;
                    n_timer     = 10'd0;
                end
            end
        end

        n_prev_hsync = i_hs;
        n_prev_fsync = i_fs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_hsync <= 1'b1;
            r_prev_fsync <= 1'b0;
            r_scanline   <= '0;
            r_remaining  <= '0;
            r_timer      <= '0;
            r_inserting  <= 1'b0;
            r_level      <= 1'b1;
        end else if (i_step) begin
            r_prev_hsync <= n_prev_hsync;
            r_prev_fsync <= n_prev_fsync;
            r_scanline   <= n_scanline;
            r_remaining  <= n_remaining;
            r_timer      <= n_timer;
            r_inserting  <= n_inserting;
            r_level      <= n_level;
        end
    end

    assign o_result.hsync_out         = n_level;
    assign o_result.fsync_out         = i_fs;
    assign o_result.chip_pause        = n_inserting;
    assign o_result.blank_line_strobe = w_strobe;

endmodule

/* sv/pal_blank_line_inserter_top.sv */
// ----------------------------------------------------------------------------
// pal_blank_line_inserter_top: blank line inserter for a video sync chain
// Tracks the video chip's sync levels, counts scanlines and holds the chip
// paused while it generates blank lines of its own timing.
// ----------------------------------------------------------------------------
// Each input transaction is one video tick and yields exactly one output
// transaction. A tick is captured in an input register, the sync core turns
// it into a result and the result waits in an output register until it is
// taken; the block takes one tick per clock cycle while the output side does
// not stall. Input stall is raised only while an item waits in the input
// register and the output register is held by a stall. A frame sync rising
// edge clears the 9-bit scanline counter; every falling edge of the chip's
// horizontal sync advances it, unless the first delay register is zero,
// which disables line counting. A match against the first or second stop
// line starts an insertion of that line's delay count of blank lines: the
// chip is paused, a local horizontal sync rises 64 ticks after each fall and
// falls every 912 ticks unless sync is inhibited, each line end giving a
// blank line strobe. Configuration must be written over the APB-style port
// only while no transaction is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module pal_blank_line_inserter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Tick input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_vdg_hsync,
    input  logic        i_vdg_fsync,
    // Result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_hsync_out,
    output logic        o_fsync_out,
    output logic        o_chip_pause,
    output logic        o_blank_line_strobe
);

    pbli_pkg::t_cfg    w_cfg;
    pbli_pkg::t_result w_result;
    pbli_pkg::t_result r_out;

    logic r_in_valid;
    logic r_in_hs;
    logic r_in_fs;
    logic r_out_valid;
    logic w_advance;
    logic w_accept;

    pbli_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The held tick moves into the output register whenever that register is
    // empty or its result is being taken in this cycle.
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    pbli_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_hs     (r_in_hs),
        .i_fs     (r_in_fs),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_hs <= i_vdg_hsync;
            r_in_fs <= i_vdg_fsync;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_hsync_out         = r_out.hsync_out;
    assign o_fsync_out         = r_out.fsync_out;
    assign o_chip_pause        = r_out.chip_pause;
    assign o_blank_line_strobe = r_out.blank_line_strobe;

endmodule

/* sv/pbli_checker.sv */
// ----------------------------------------------------------------------------
// pbli_checker: port-level checks of the blank line inserter
// Watches the handshakes and the configuration port of the top level.
// ----------------------------------------------------------------------------
module pbli_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       pready,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_hsync_out,
    input logic       o_fsync_out,
    input logic       o_chip_pause,
    input logic       o_blank_line_strobe
);

    // Input stall only arises from a stalled, full output side.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while output side is free");

    // Every accepted transaction passes through the input register and shows
    // up at the output when the output side keeps taking results.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !i_out_stall) ##1 !i_out_stall
        |=> o_out_valid)
        else $error("accepted transaction did not reach the output");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_hsync_out)
        && $stable(o_fsync_out) && $stable(o_chip_pause)
        && $stable(o_blank_line_strobe)))
        else $error("stalled output changed");

    // The configuration port never waits.
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready dropped");

endmodule

bind pal_blank_line_inserter_top pbli_checker u_pbli_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .pready              (pready),
    .i_in_valid          (i_in_valid),
    .o_in_stall          (o_in_stall),
    .o_out_valid         (o_out_valid),
    .i_out_stall         (i_out_stall),
    .o_hsync_out         (o_hsync_out),
    .o_fsync_out         (o_fsync_out),
    .o_chip_pause        (o_chip_pause),
    .o_blank_line_strobe (o_blank_line_strobe)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the blank line inserter
// Streams video ticks into the block, keeps its own copy of the sync chain
// behavior and compares every result transaction with the value it computes.
// ----------------------------------------------------------------------------
// Stimulus is a queue of ticks that the main initial block fills phase by
// phase. A clocked driver offers the ticks at the falling edge and a clocked
// monitor takes results at the rising edge. Every accepted tick is run
// through the bench's own sync chain, which pushes the result it must cause.
// The register port is only written while nothing is in flight.
// ----------------------------------------------------------------------------
module tb_top;

    // A single video tick as the chip presents it.
    typedef struct packed {
        logic hs;
        logic fs;
    } t_tick;

    // Longest receiver hold-off of the pressure test, and the number of
    // cycles without any accepted transaction that counts as a hang.
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned QUIET_LIMIT = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_vdg_hsync = 1'b1;
    logic        i_vdg_fsync = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_hsync_out;
    logic        o_fsync_out;
    logic        o_chip_pause;
    logic        o_blank_line_strobe;

    pal_blank_line_inserter_top u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_vdg_hsync         (i_vdg_hsync),
        .i_vdg_fsync         (i_vdg_fsync),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_hsync_out         (o_hsync_out),
        .o_fsync_out         (o_fsync_out),
        .o_chip_pause        (o_chip_pause),
        .o_blank_line_strobe (o_blank_line_strobe)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Ticks waiting to be offered, and the results the block still owes.
    t_tick             pending_ticks[$];
    pbli_pkg::t_result due_results[$];

    // Register values as the bench believes the block holds them.
    pbli_pkg::t_cfg    cfg = '0;

    // Sync chain state, at the block's own widths and reset values.
    logic        last_hs = 1'b1;
    logic        last_fs = 1'b0;
    logic [8:0]  scan_line = '0;
    logic [7:0]  lines_left = '0;
    logic [9:0]  line_timer = '0;
    logic        pausing = 1'b0;
    logic        drive_level = 1'b1;

    // Idling percentages of the current phase and the pressure hand-off.
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_asks = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;

    logic        tick_taken = 1'b0;
    int unsigned fail_cnt = 0;
    int unsigned quiet_cycles = 0;
    int unsigned edge_items = 0;
    logic        in_filler = 1'b0;

    // One video tick through the sync chain. The generated line timing is
    // applied first, then the frame sync edge, then the chip's horizontal
    // sync edge, so a chip edge always overrides a generated level change.
    task automatic run_sync_tick(input logic hs, input logic fs);
        pbli_pkg::t_result r;
        r.blank_line_strobe = 1'b0;
        if (pausing) begin
            line_timer = line_timer + 10'd1;
            if (line_timer == pbli_pkg::PULSE_TICKS)
                drive_level = 1'b1;
            if (line_timer == pbli_pkg::LINE_TICKS) begin
                r.blank_line_strobe = 1'b1;
                if (!cfg.sync_inhibit)
                    drive_level = 1'b0;
                lines_left = lines_left - 8'd1;
                if (lines_left == 8'd0)
                    pausing = 1'b0;
                else
                    line_timer = '0;
            end
        end
        if (fs && !last_fs)
            scan_line = '0;
        if (hs != last_hs) begin
            drive_level = hs;
            // A zero first delay disables line counting altogether.
            if (!hs && cfg.first_delay_lines != 8'd0) begin
                scan_line = scan_line + 9'd1;
                if (scan_line == cfg.first_stop_line)
                    lines_left = cfg.first_delay_lines;
                else if (scan_line == cfg.second_stop_line)
                    lines_left = cfg.second_delay_lines;
                // Also restarts the timing when the chip falls mid-insertion.
                if (lines_left != 8'd0) begin
                    pausing = 1'b1;
                    line_timer = '0;
                end
            end
        end
        last_hs = hs;
        last_fs = fs;
        r.hsync_out = drive_level;
        r.fsync_out = fs;
        r.chip_pause = pausing;
        due_results.push_back(r);
    endtask

    // Input side: a tick is taken at a rising edge with valid high and stall
    // low. The flag tells the driver at the next falling edge to move on.
    always @(posedge i_clk) begin : capture_ticks
        tick_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall)
            run_sync_tick(i_vdg_hsync, i_vdg_fsync);
    end

    // Driver: a tick once offered stays on the port until it is taken.
    always @(negedge i_clk) begin : drive_ticks
        t_tick nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || tick_taken) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_ticks.pop_front();
                i_in_valid <= 1'b1;
                i_vdg_hsync <= nxt.hs;
                i_vdg_fsync <= nxt.fs;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall, or a long hold-off when one is requested.
    always @(negedge i_clk) begin : drive_stall
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asks) begin
            hold_served <= hold_asks;
            hold_left <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor: each result transaction is held against the oldest result
    // still owed.
    always @(posedge i_clk) begin : check_results
        pbli_pkg::t_result got;
        pbli_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_hsync_out, o_fsync_out, o_chip_pause, o_blank_line_strobe};
            if (due_results.size() == 0) begin
                $display({"%0t: result with none owed, expected none, ",
                          "actual hs=%b fs=%b pause=%b strobe=%b"},
                         $time, got.hsync_out, got.fsync_out, got.chip_pause,
                         got.blank_line_strobe);
                fail_cnt++;
            end else begin
                want = due_results.pop_front();
                if (got !== want) begin
                    $display({"%0t: result mismatch, expected hs=%b fs=%b pause=%b ",
                              "strobe=%b, actual hs=%b fs=%b pause=%b strobe=%b"},
                             $time, want.hsync_out, want.fsync_out, want.chip_pause,
                             want.blank_line_strobe, got.hsync_out, got.fsync_out,
                             got.chip_pause, got.blank_line_strobe);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL pal_blank_line_inserter_top");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        case (idx)
            pbli_pkg::REG_FIRST_DELAY:  cfg.first_delay_lines = val[7:0];
            pbli_pkg::REG_SECOND_DELAY: cfg.second_delay_lines = val[7:0];
            pbli_pkg::REG_FIRST_STOP:   cfg.first_stop_line = val[8:0];
            pbli_pkg::REG_SECOND_STOP:  cfg.second_stop_line = val[8:0];
            pbli_pkg::REG_SYNC_INHIBIT: cfg.sync_inhibit = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] fd, input logic [7:0] sd,
                              input logic [8:0] fst, input logic [8:0] sst,
                              input logic inh);
        write_reg(pbli_pkg::REG_FIRST_DELAY, 32'(fd));
        write_reg(pbli_pkg::REG_SECOND_DELAY, 32'(sd));
        write_reg(pbli_pkg::REG_FIRST_STOP, 32'(fst));
        write_reg(pbli_pkg::REG_SECOND_STOP, 32'(sst));
        write_reg(pbli_pkg::REG_SYNC_INHIBIT, 32'(inh));
    endtask

    // Waits until every queued tick is taken and every owed result is in,
    // then lets the input and output registers settle.
    task automatic wait_quiet();
        while (pending_ticks.size() != 0 || i_in_valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic push_tick(input logic hs, input logic fs);
        t_tick t;
        t.hs = hs;
        t.fs = fs;
        pending_ticks.push_back(t);
        if (!in_filler)
            edge_items++;
    endtask

    // Holds the chip's sync low for about n blank lines, as a paused chip
    // would. The end lands a little before or after the last generated fall,
    // and now and then the chip toggles its sync in the middle.
    task automatic hold_blank(input int unsigned n_lines, inout logic [8:0] line_no);
        int unsigned len;
        int unsigned cut;
        len = n_lines * pbli_pkg::LINE_TICKS + $urandom_range(40) - 20;
        cut = ($urandom_range(3) == 0) ? $urandom_range(len - 2, 1) : 0;
        in_filler = 1'b1;
        for (int unsigned k = 1; k < len; k++) begin
            if (k == cut) begin
                push_tick(1'b1, 1'b0);
                push_tick(1'b0, 1'b0);
                line_no = line_no + 9'd1;
                k++;
            end else begin
                push_tick(1'b0, 1'b0);
            end
        end
        in_filler = 1'b0;
    endtask

    // Follows the line count as the block should see it, right after a chip
    // fall, and gives the chip time to sit out an insertion.
    task automatic count_line(inout logic [8:0] line_no);
        logic [7:0] n;
        n = 8'd0;
        if (cfg.first_delay_lines != 8'd0) begin
            line_no = line_no + 9'd1;
            if (line_no == cfg.first_stop_line)
                n = cfg.first_delay_lines;
            else if (line_no == cfg.second_stop_line)
                n = cfg.second_delay_lines;
        end
        if (n != 8'd0)
            hold_blank(n, line_no);
    endtask

    // One short frame: a frame sync pulse, sometimes on a line fall, then a
    // handful of short lines. A few frames start with a burst of noise.
    task automatic gen_frame();
        int unsigned n_lines;
        logic [8:0]  line_no;
        line_no = '0;
        n_lines = $urandom_range(12, 6);
        if ($urandom_range(99) < 15)
            repeat ($urandom_range(40, 20))
                push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        if ($urandom_range(3) == 0) begin
            push_tick(1'b0, 1'b1);
            count_line(line_no);
        end else begin
            push_tick(1'b1, 1'b1);
        end
        repeat ($urandom_range(2)) push_tick(i_vdg_hsync, 1'b1);
        for (int unsigned l = 0; l < n_lines; l++) begin
            repeat ($urandom_range(5, 1)) push_tick(1'b1, 1'b0);
            push_tick(1'b0, 1'b0);
            count_line(line_no);
            repeat ($urandom_range(3)) push_tick(1'b0, 1'b0);
        end
        push_tick(1'b1, 1'b0);
    endtask

    int unsigned send_pcts[4] = '{0, 72, 0, 31};
    int unsigned stall_pcts[4] = '{0, 0, 72, 31};

    initial begin : run_test
        logic [8:0] line_no;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Registers at reset: the first delay is zero, so edges only pass
        // through. Frame and line edges also share a tick here.
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b0);
        wait_quiet();

        // Line 1 hits the second stop line with a zero delay, which must do
        // nothing. Line 2 inserts one blank line, and the chip rises in the
        // very tick of the generated fall, so the chip's level wins.
        set_config(8'd1, 8'd0, 9'd2, 9'd1, 1'b0);
        push_tick(1'b1, 1'b1);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        repeat (pbli_pkg::LINE_TICKS - 1) push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        wait_quiet();

        // Frame sync rises in the tick of a line fall, so the counter clears
        // before it advances and line 1 starts a two-line insertion. The chip
        // then falls right on the pulse tick: its level wins, line 2 matches
        // and reloads three lines. Generated falls are inhibited.
        set_config(8'd2, 8'd3, 9'd1, 9'd2, 1'b1);
        push_tick(1'b0, 1'b1);
        repeat (pbli_pkg::PULSE_TICKS - 1) push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        repeat (3 * pbli_pkg::LINE_TICKS + 20) push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        wait_quiet();

        // Counter wrap: line 511 inserts one line at the top stop line, and
        // the wrap to 0 inserts three blank lines.
        set_config(8'd3, 8'd1, 9'd0, 9'd511, 1'b0);
        push_tick(1'b1, 1'b1);
        push_tick(1'b1, 1'b0);
        line_no = '0;
        repeat (512) begin
            push_tick(1'b0, 1'b0);
            count_line(line_no);
            push_tick(1'b1, 1'b0);
        end
        wait_quiet();

        // Random frames under each idling pattern. In the first pattern the
        // receiver holds off once for a long stretch while the sender keeps
        // offering ticks, so the block fills and stalls its input.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = send_pcts[p];
            stall_pct = stall_pcts[p];
            edge_items = 0;
            while (edge_items < 175) begin
                wait_quiet();
                set_config(($urandom_range(4) == 0) ? 8'd0 : 8'($urandom_range(3, 1)),
                           8'($urandom_range(3)), 9'($urandom_range(10, 1)),
                           9'($urandom_range(10, 1)), 1'($urandom_range(1)));
                repeat (2) begin
                    gen_frame();
                    if (p == 0 && hold_asks == 0)
                        hold_asks++;
                end
            end
        end

        wait_quiet();
        repeat (8) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("PASS pal_blank_line_inserter_top");
        else
            $display("FAIL pal_blank_line_inserter_top");
        $finish;
    end

endmodule

/* pal_blank_line_inserter_top.f */
sv/pbli_pkg.sv
sv/pbli_cfg.sv
sv/pbli_core.sv
sv/pal_blank_line_inserter_top.sv
sv/pbli_checker.sv
tb/sv/tb_top.sv
